// ===== design/glh_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the gray-level histogram unit.
// No dependencies; every other file of the block but glh_ram uses this package.
package glh_pkg;

	localparam int LEVELS_DEF     = 256;
	localparam int COUNT_BITS_DEF = 24;

	localparam int KIND_W   = 2;
	localparam int LEVEL_W  = 8;
	localparam int COUNT_W  = 24;
	localparam int HEIGHT_W = 9;

	// Quotient is at most LEVELS <= 256, so nine quotient bits cover it.
	localparam int DIV_STEPS = HEIGHT_W;

	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PIXEL = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	typedef struct packed {
		logic capture;  // latch address, range flag and bin index
		logic sel_pix;  // address comes from the pixel value
		logic rd_en;    // read the bin memory
		logic clear;    // drop all bins and the peak
		logic upd;      // write back the incremented count
		logic mul;      // scale the count by LEVELS, load the divider
		logic div_step; // one shift-subtract step
		logic load_out; // move the result into the output register
	} glh_cmd_t;

	typedef struct packed {
		logic out_free; // output register can take a result this cycle
	} glh_sts_t;

endpackage

// ===== design/glh_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package needed.
module glh_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/glh_ctrl.sv =====
`timescale 1ns / 1ps
// Sequencer of the histogram unit: accepts beats, steps the datapath.
// Depends on glh_pkg for kind codes and the command/status structs.
module glh_ctrl (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       item_valid,
	output logic                       item_stall,
	input  logic [glh_pkg::KIND_W-1:0] kind,
	output glh_pkg::glh_cmd_t          cmd,
	input  glh_pkg::glh_sts_t          sts
);

	import glh_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_UPD  = 3'd1;
	localparam logic [2:0] ST_MUL  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_OUT  = 3'd4;

	localparam int STEP_W = $clog2(DIV_STEPS);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(DIV_STEPS - 1);

	logic [2:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q, step_d;
	logic              accept;

	assign item_stall = (state_q != ST_IDLE);
	assign accept     = item_valid && !item_stall;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		step_d  = step_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					unique case (kind)
						KIND_CLEAR: begin
							cmd.clear = 1'b1;
						end
						KIND_PIXEL: begin
							cmd.capture = 1'b1;
							cmd.sel_pix = 1'b1;
							cmd.rd_en   = 1'b1;
							state_d     = ST_UPD;
						end
						KIND_READ: begin
							cmd.capture = 1'b1;
							cmd.rd_en   = 1'b1;
							state_d     = ST_MUL;
						end
						default: begin
							// unused kind: drop the beat
						end
					endcase
				end
			end
			ST_UPD: begin
				cmd.upd = 1'b1;
				state_d = ST_IDLE;
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				step_d  = '0;
				state_d = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				step_d       = step_q + 1'b1;
				if (step_q == LAST_STEP) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: begin
				// hold until the output register frees up
				if (sts.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

endmodule

// ===== design/glh_dp.sv =====
`timescale 1ns / 1ps
// Datapath of the histogram unit: bin memory, valid bits, peak, scaling
// divider and output register. Depends on glh_pkg and glh_ram.
module glh_dp #(
	parameter int LEVELS     = glh_pkg::LEVELS_DEF,
	parameter int COUNT_BITS = glh_pkg::COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [glh_pkg::LEVEL_W-1:0]  pixel_value,
	input  logic [glh_pkg::LEVEL_W-1:0]  bin_index,
	input  glh_pkg::glh_cmd_t            cmd,
	output glh_pkg::glh_sts_t            sts,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [glh_pkg::LEVEL_W-1:0]  read_bin,
	output logic [glh_pkg::COUNT_W-1:0]  bin_count,
	output logic [glh_pkg::HEIGHT_W-1:0] bar_height,
	output logic                         histogram_empty
);

	import glh_pkg::*;

	localparam int AW = $clog2(LEVELS);
	localparam int PW = COUNT_BITS + HEIGHT_W;
	localparam logic [COUNT_BITS-1:0] CMAX   = {COUNT_BITS{1'b1}};
	localparam logic [PW-1:0]         LVL_PW = PW'(LEVELS);
	localparam logic [LEVEL_W:0]      LVL_CMP = (LEVEL_W + 1)'(LEVELS);

	logic [LEVEL_W-1:0]    src;
	logic [AW-1:0]         addr_q;
	logic                  in_range_q;
	logic [LEVEL_W-1:0]    idx_q;
	logic [LEVELS-1:0]     valid_q;
	logic                  rd_vld_q;
	logic [COUNT_BITS-1:0] peak_q;
	logic [COUNT_BITS-1:0] rdata;
	logic [COUNT_BITS-1:0] cur_cnt;
	logic [COUNT_BITS-1:0] new_cnt;
	logic                  we;
	logic [COUNT_BITS-1:0] count_q;
	logic [PW-1:0]         rem_q;
	logic [PW-1:0]         dvs_q;
	logic [HEIGHT_W-1:0]   quo_q;
	logic                  ge;
	logic [31:0]           count_ext;
	logic                  empty;

	logic                  out_valid_q;
	logic [LEVEL_W-1:0]    out_bin_q;
	logic [COUNT_W-1:0]    out_count_q;
	logic [HEIGHT_W-1:0]   out_height_q;
	logic                  out_empty_q;

	assign src = cmd.sel_pix ? pixel_value : bin_index;

	assign cur_cnt = (in_range_q && rd_vld_q) ? rdata : '0;
	assign new_cnt = (cur_cnt == CMAX) ? cur_cnt : cur_cnt + 1'b1;
	assign we      = cmd.upd && in_range_q;

	glh_ram #(
		.WIDTH (COUNT_BITS),
		.DEPTH (LEVELS)
	) u_bins (
		.clk   (clk),
		.we    (we),
		.waddr (addr_q),
		.wdata (new_cnt),
		.re    (cmd.rd_en),
		.raddr (src[AW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			addr_q     <= src[AW-1:0];
			in_range_q <= ({1'b0, src} < LVL_CMP);
			idx_q      <= src;
		end
		if (cmd.rd_en) begin
			rd_vld_q <= valid_q[src[AW-1:0]];
		end
	end

	// An entry whose valid bit is low reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			peak_q  <= '0;
		end else if (cmd.clear) begin
			valid_q <= '0;
			peak_q  <= '0;
		end else if (we) begin
			valid_q[addr_q] <= 1'b1;
			if (new_cnt > peak_q) begin
				peak_q <= new_cnt;
			end
		end
	end

	// Restoring divide of count*LEVELS by the peak, one quotient bit a step.
	assign ge = (rem_q >= dvs_q);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			count_q <= cur_cnt;
			rem_q   <= PW'(cur_cnt) * LVL_PW;
			dvs_q   <= PW'(peak_q) << (HEIGHT_W - 1);
			quo_q   <= '0;
		end else if (cmd.div_step) begin
			if (ge) begin
				rem_q <= rem_q - dvs_q;
			end
			quo_q <= {quo_q[HEIGHT_W-2:0], ge};
			dvs_q <= dvs_q >> 1;
		end
	end

	assign empty     = (peak_q == '0);
	assign count_ext = 32'(count_q);

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_bin_q    <= idx_q;
			out_count_q  <= count_ext[COUNT_W-1:0];
			out_height_q <= empty ? '0 : quo_q;
			out_empty_q  <= empty;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.out_free = !out_valid_q || !result_stall;

	assign result_valid    = out_valid_q;
	assign read_bin        = out_bin_q;
	assign bin_count       = out_count_q;
	assign bar_height      = out_height_q;
	assign histogram_empty = out_empty_q;

endmodule

// ===== design/gray_level_histogram_unit.sv =====
`timescale 1ns / 1ps
// Gray-level histogram unit: LEVELS-bin counter (256 by default) with normalized read-out.
// Depends on glh_pkg, glh_ctrl and glh_dp (which holds glh_ram).
//
// A clear beat never stalls the input. A pixel beat runs a memory read, then
// the write back of the saturated increment, and the input stalls during the
// write back. A read beat runs a memory read and stalls the input for the
// steps after it: scaling by LEVELS, nine steps of the shift-subtract divider
// that forms floor(count*LEVELS/peak), and the load of the output register.
// The load waits further while an earlier result still sits unaccepted in
// that register. Once loaded, the result waits there while the next items
// are taken. Bins come out of reset as zero through per-bin valid bits, so
// no clearing pass is needed.
module gray_level_histogram_unit #(
	parameter int LEVELS     = glh_pkg::LEVELS_DEF,
	parameter int COUNT_BITS = glh_pkg::COUNT_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         item_valid,
	output logic                         item_stall,
	input  logic [glh_pkg::KIND_W-1:0]   kind,
	input  logic [glh_pkg::LEVEL_W-1:0]  pixel_value,
	input  logic [glh_pkg::LEVEL_W-1:0]  bin_index,
	output logic                         result_valid,
	input  logic                         result_stall,
	output logic [glh_pkg::LEVEL_W-1:0]  read_bin,
	output logic [glh_pkg::COUNT_W-1:0]  bin_count,
	output logic [glh_pkg::HEIGHT_W-1:0] bar_height,
	output logic                         histogram_empty
);

	import glh_pkg::*;

	glh_cmd_t cmd;
	glh_sts_t sts;

	glh_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.kind       (kind),
		.cmd        (cmd),
		.sts        (sts)
	);

	glh_dp #(
		.LEVELS     (LEVELS),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.pixel_value     (pixel_value),
		.bin_index       (bin_index),
		.cmd             (cmd),
		.sts             (sts),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.read_bin        (read_bin),
		.bin_count       (bin_count),
		.bar_height      (bar_height),
		.histogram_empty (histogram_empty)
	);

endmodule
